// ===== hdl/rvalu_pkg.sv =====
// Package: widths, opcodes and the beat record carried down the cell chain.
`timescale 1ns / 1ps
package rvalu_pkg;
   localparam int XLEN = 64;
   localparam int HALF = XLEN / 2;
   localparam int SHW  = $clog2(XLEN);

   localparam logic [1:0] VAR_BASE = 2'd0;
   localparam logic [1:0] VAR_ALT  = 2'd1;
   localparam logic [1:0] VAR_MEXT = 2'd2;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SLL  = 3'd1;
   localparam logic [2:0] OP_SLT  = 3'd2;
   localparam logic [2:0] OP_SLTU = 3'd3;
   localparam logic [2:0] OP_XOR  = 3'd4;
   localparam logic [2:0] OP_SRL  = 3'd5;
   localparam logic [2:0] OP_OR   = 3'd6;
   localparam logic [2:0] OP_AND  = 3'd7;

   localparam logic [2:0] OP_MUL    = 3'd0;
   localparam logic [2:0] OP_MULH   = 3'd1;
   localparam logic [2:0] OP_MULHSU = 3'd2;
   localparam logic [2:0] OP_MULHU  = 3'd3;
   localparam logic [2:0] OP_DIV    = 3'd4;
   localparam logic [2:0] OP_DIVU   = 3'd5;
   localparam logic [2:0] OP_REM    = 3'd6;
   localparam logic [2:0] OP_REMU   = 3'd7;

   typedef struct packed {
      logic            mext;
      logic [2:0]      op;
      logic [XLEN-1:0] base_res;
      logic [XLEN-1:0] a;
      logic [XLEN-1:0] corr;
      logic [XLEN-1:0] p00;
      logic [XLEN-1:0] p01;
      logic [XLEN-1:0] p10;
      logic [XLEN-1:0] p11;
      logic [XLEN-1:0] lo;
      logic [XLEN-1:0] hi;
      logic [XLEN-1:0] rem;
      logic [XLEN-1:0] q;
      logic [XLEN-1:0] d;
      logic            neg_q;
      logic            neg_r;
      logic            div0;
   } pay_type;
endpackage

// ===== hdl/rvalu_front.sv =====
// Front cell: base ALU, partial products, divide setup.
`timescale 1ns / 1ps
module rvalu_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [63:0]                 in_a,
   input  logic [63:0]                 in_b,
   input  logic [2:0]                  in_op,
   input  logic [1:0]                  in_var,
   input  logic                        next_ready,
   output logic                        in_ready,
   output logic                        v_ff,
   output rvalu_pkg::pay_type          pay_ff
);
   logic [rvalu_pkg::XLEN-1:0] a, b, res, ah, al, bh, bl;
   logic [rvalu_pkg::SHW-1:0]  sh;
   logic                       as, bs, alt, sdiv;
   logic                       v_in;
   rvalu_pkg::pay_type         pay_in;

   always_comb begin
      a   = in_a[rvalu_pkg::XLEN-1:0];
      b   = in_b[rvalu_pkg::XLEN-1:0];
      sh  = b[rvalu_pkg::SHW-1:0];
      as  = a[rvalu_pkg::XLEN-1];
      bs  = b[rvalu_pkg::XLEN-1];
      alt = (in_var == rvalu_pkg::VAR_ALT);
      case (in_op)
         rvalu_pkg::OP_ADD:  res = alt ? a - b : a + b;
         rvalu_pkg::OP_SLL:  res = a << sh;
         rvalu_pkg::OP_SLT:  res = rvalu_pkg::XLEN'($signed(a) < $signed(b));
         rvalu_pkg::OP_SLTU: res = rvalu_pkg::XLEN'(a < b);
         rvalu_pkg::OP_XOR:  res = a ^ b;
         rvalu_pkg::OP_SRL:  res = alt ? rvalu_pkg::XLEN'($signed(a) >>> sh) : a >> sh;
         rvalu_pkg::OP_OR:   res = a | b;
         default:            res = a & b;
      endcase
      ah = {{rvalu_pkg::HALF{1'b0}}, a[rvalu_pkg::XLEN-1:rvalu_pkg::HALF]};
      al = {{rvalu_pkg::HALF{1'b0}}, a[rvalu_pkg::HALF-1:0]};
      bh = {{rvalu_pkg::HALF{1'b0}}, b[rvalu_pkg::XLEN-1:rvalu_pkg::HALF]};
      bl = {{rvalu_pkg::HALF{1'b0}}, b[rvalu_pkg::HALF-1:0]};
      sdiv = (in_op == rvalu_pkg::OP_DIV) || (in_op == rvalu_pkg::OP_REM);
      pay_in          = '0;
      pay_in.mext     = (in_var == rvalu_pkg::VAR_MEXT);
      pay_in.op       = in_op;
      pay_in.base_res = res;
      pay_in.a        = a;
      case (in_op)
         rvalu_pkg::OP_MULH:   pay_in.corr = (as ? b : '0) + (bs ? a : '0);
         rvalu_pkg::OP_MULHSU: pay_in.corr = as ? b : '0;
         default:              pay_in.corr = '0;
      endcase
      pay_in.p00   = al * bl;
      pay_in.p01   = al * bh;
      pay_in.p10   = ah * bl;
      pay_in.p11   = ah * bh;
      pay_in.q     = (sdiv && as) ? -a : a;
      pay_in.d     = (sdiv && bs) ? -b : b;
      pay_in.neg_q = sdiv && (as ^ bs);
      pay_in.neg_r = sdiv && as;
      pay_in.div0  = (b == '0);
      in_ready     = !v_ff || next_ready;
      v_in         = in_ready ? in_valid : v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (in_ready) begin
         pay_ff <= pay_in;
      end
   end
endmodule

// ===== hdl/rvalu_prod.sv =====
// Product cell: sums four partial products, sign-corrects high half.
`timescale 1ns / 1ps
module rvalu_prod (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rvalu_pkg::pay_type in_pay,
   input  logic               next_ready,
   output logic               in_ready,
   output logic               v_ff,
   output rvalu_pkg::pay_type pay_ff
);
   logic [2*rvalu_pkg::XLEN-1:0] prod;
   logic                         v_in;
   rvalu_pkg::pay_type           pay_in;

   always_comb begin
      prod = {in_pay.p11, in_pay.p00}
           + ((2*rvalu_pkg::XLEN)'(in_pay.p01) << rvalu_pkg::HALF)
           + ((2*rvalu_pkg::XLEN)'(in_pay.p10) << rvalu_pkg::HALF);
      pay_in    = in_pay;
      pay_in.lo = prod[rvalu_pkg::XLEN-1:0];
      pay_in.hi = prod[2*rvalu_pkg::XLEN-1:rvalu_pkg::XLEN] - in_pay.corr;
      in_ready  = !v_ff || next_ready;
      v_in      = in_ready ? in_valid : v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (in_ready) begin
         pay_ff <= pay_in;
      end
   end
endmodule

// ===== hdl/rvalu_div_cell.sv =====
// Divide cell: one restoring quotient bit per cell.
`timescale 1ns / 1ps
module rvalu_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rvalu_pkg::pay_type in_pay,
   input  logic               next_ready,
   output logic               in_ready,
   output logic               v_ff,
   output rvalu_pkg::pay_type pay_ff
);
   logic [rvalu_pkg::XLEN:0] trial, diff;
   logic                     v_in;
   rvalu_pkg::pay_type       pay_in;

   always_comb begin
      trial  = {in_pay.rem, in_pay.q[rvalu_pkg::XLEN-1]};
      diff   = trial - {1'b0, in_pay.d};
      pay_in = in_pay;
      pay_in.rem = diff[rvalu_pkg::XLEN] ? trial[rvalu_pkg::XLEN-1:0]
                                          : diff[rvalu_pkg::XLEN-1:0];
      pay_in.q   = {in_pay.q[rvalu_pkg::XLEN-2:0], !diff[rvalu_pkg::XLEN]};
      in_ready   = !v_ff || next_ready;
      v_in       = in_ready ? in_valid : v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (in_ready) begin
         pay_ff <= pay_in;
      end
   end
endmodule

// ===== hdl/rvalu_back.sv =====
// Back cell: sign fixup, special cases, result select and output register.
`timescale 1ns / 1ps
module rvalu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rvalu_pkg::pay_type in_pay,
   input  logic               out_stall,
   output logic               in_ready,
   output logic               out_valid,
   output logic [63:0]        out_result
);
   logic [rvalu_pkg::XLEN-1:0] res;
   logic                       v_ff, v_in;
   logic [63:0]                res_ff;

   always_comb begin
      if (!in_pay.mext) begin
         res = in_pay.base_res;
      end else begin
         case (in_pay.op)
            rvalu_pkg::OP_MUL:  res = in_pay.lo;
            rvalu_pkg::OP_MULH, rvalu_pkg::OP_MULHSU, rvalu_pkg::OP_MULHU: begin
               res = in_pay.hi;
            end
            rvalu_pkg::OP_DIV, rvalu_pkg::OP_DIVU: begin
               res = in_pay.div0 ? '1 : (in_pay.neg_q ? -in_pay.q : in_pay.q);
            end
            default: begin
               res = in_pay.div0 ? in_pay.a : (in_pay.neg_r ? -in_pay.rem : in_pay.rem);
            end
         endcase
      end
      in_ready = !v_ff || !out_stall;
      v_in     = in_ready ? in_valid : v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (in_ready) begin
         res_ff <= 64'(res);
      end
   end

   assign out_valid  = v_ff;
   assign out_result = res_ff;
endmodule

// ===== hdl/rv64im_integer_alu.sv =====
// RV64IM integer ALU: front, product, divide-cell chain and back cell.
// Each beat is registered in the front cell, the product cell, the XLEN divide cells and the back cell, in that order.
// Throughput: one beat per cycle while rsp_stall does not hold the chain.
// Empty cells fill under a stalled output, so the chain absorbs bubbles.
// Reset: synchronous, active high, clears all valid flags; no payload reset.
`timescale 1ns / 1ps
module rv64im_integer_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   input  logic [2:0]  req_opcode,
   input  logic [1:0]  req_variant,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result
);
   localparam int N = rvalu_pkg::XLEN;

   logic               front_v, front_rdy, prod_v, prod_rdy, back_rdy;
   rvalu_pkg::pay_type front_pay, prod_pay;
   logic [N:0]         cv, crdy;
   rvalu_pkg::pay_type cpay [N+1];

   rvalu_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid),
      .in_a(req_operand_a), .in_b(req_operand_b), .in_op(req_opcode),
      .in_var(req_variant), .next_ready(prod_rdy), .in_ready(front_rdy),
      .v_ff(front_v), .pay_ff(front_pay));

   rvalu_prod u_prod (
      .clock(clock), .reset(reset), .in_valid(front_v), .in_pay(front_pay),
      .next_ready(crdy[0]), .in_ready(prod_rdy), .v_ff(prod_v), .pay_ff(prod_pay));

   assign cv[0]   = prod_v;
   assign cpay[0] = prod_pay;
   assign crdy[N] = back_rdy;

   for (genvar i = 0; i < N; i++) begin : g_div
      rvalu_div_cell u_cell (
         .clock(clock), .reset(reset), .in_valid(cv[i]), .in_pay(cpay[i]),
         .next_ready(crdy[i+1]), .in_ready(crdy[i]), .v_ff(cv[i+1]),
         .pay_ff(cpay[i+1]));
   end

   rvalu_back u_back (
      .clock(clock), .reset(reset), .in_valid(cv[N]), .in_pay(cpay[N]),
      .out_stall(rsp_stall), .in_ready(back_rdy), .out_valid(rsp_valid),
      .out_result(rsp_result));

   assign req_stall = !front_rdy;

`ifndef SYNTHESIS
   a_accept_fills_front: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> front_v)
      else $error("accepted beat did not enter front cell");
   a_reset_clears_out: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !front_v |-> !req_stall)
      else $error("input stalled with empty front cell");
`endif
endmodule
